>>> rtl/core/mptm_pkg.sv
// Package for the multiscale pixel tone mapper: fixed-point constants,
// table types and the elaboration-time builders for the log2/exp2 and pixel tables.
// No dependencies.
`default_nettype none

package mptm_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int LOG_TABLE_DEPTH = 1024;
	localparam int IDX_W           = $clog2(LOG_TABLE_DEPTH);
	localparam int REM_W           = FRAC_BITS - IDX_W;

	localparam logic [24:0] ONE_Q   = 25'd1 << FRAC_BITS;
	localparam logic [24:0] EXP_CAP = ONE_Q << 8;

	typedef logic [16:0] lg_word_t;
	typedef logic [17:0] ex_word_t;
	typedef lg_word_t    lg_rom_t  [0:LOG_TABLE_DEPTH];
	typedef ex_word_t    ex_rom_t  [0:LOG_TABLE_DEPTH];
	typedef logic [16:0] iq_tab_t  [0:255];
	typedef logic [32:0] rcp_tab_t [0:255];

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (b > n) b = b >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2(1 + i/D) by repeated squaring at 30 fraction bits
	function automatic lg_rom_t build_lg_rom();
		lg_rom_t     t;
		logic [63:0] x;
		logic [63:0] r;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			if (i == LOG_TABLE_DEPTH) begin
				t[i] = 17'(ONE_Q);
			end else begin
				x = (64'(LOG_TABLE_DEPTH + i) << 30) / LOG_TABLE_DEPTH;
				r = '0;
				for (int k = 0; k < 32; k++) begin
					x = (x * x) >> 30;
					r = r << 1;
					if (x >= (64'd1 << 31)) begin
						x = x >> 1;
						r = r | 64'd1;
					end
				end
				t[i] = 17'((r + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
			end
		end
		return t;
	endfunction

	// 2^(i/D) as a product of repeated square roots of two
	function automatic ex_rom_t build_ex_rom();
		ex_rom_t     t;
		logic [63:0] roots [1:32];
		logic [63:0] f;
		logic [63:0] y;
		roots[1] = isqrt64(64'd1 << 61);
		for (int k = 2; k <= 32; k++) roots[k] = isqrt64(roots[k - 1] << 30);
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			if (i == LOG_TABLE_DEPTH) begin
				t[i] = 18'(ONE_Q << 1);
			end else begin
				f = (64'(i) << 32) / LOG_TABLE_DEPTH;
				y = 64'd1 << 30;
				for (int k = 1; k <= 32; k++) begin
					if (f[32 - k]) y = (y * roots[k]) >> 30;
				end
				t[i] = 18'((y + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
			end
		end
		return t;
	endfunction

	// I = round(v / 255) in Q16
	function automatic iq_tab_t build_iq_tab();
		iq_tab_t t;
		for (int v = 0; v < 256; v++) begin
			t[v] = 17'(((64'(v) << FRAC_BITS) + 64'd127) / 255);
		end
		return t;
	endfunction

	// floor(2^32 / (v + 1)), never above the true quotient
	function automatic rcp_tab_t build_rcp_tab();
		rcp_tab_t t;
		for (int v = 0; v < 256; v++) begin
			t[v] = 33'((64'd1 << 32) / 64'(v + 1));
		end
		return t;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mptm_pow.sv
// Pipelined fixed-point power unit y = x^e = exp2(e * log2 x), seven register stages.
// Depends on mptm_pkg for the log2/exp2 tables and Q16 constants.
`default_nettype none

module mptm_pow (
	input  logic        clk,
	input  logic        en,
	input  logic [24:0] x,
	input  logic [24:0] e,
	output logic [24:0] y
);
	import mptm_pkg::*;

	localparam lg_rom_t LG_ROM = build_lg_rom();
	localparam ex_rom_t EX_ROM = build_ex_rom();

	// stage a
	logic [4:0]  lead;
	logic [24:0] e_sat;
	logic [24:0] x_a;
	logic [24:0] e_a;
	logic        zero_a;
	logic [4:0]  lead_a;

	// stage b: log table read
	logic [24:0]      norm;
	logic [IDX_W-1:0] lg_idx;
	lg_word_t         lg_lo_b;
	lg_word_t         lg_hi_b;
	logic [REM_W-1:0] lg_rem_b;
	logic signed [5:0] expo_b;
	logic [24:0]      e_b;
	logic             zero_b;

	// stage c: log2 value
	lg_word_t          lg_slope;
	logic [22:0]       lg_step;
	logic signed [21:0] lg_c;
	logic [24:0]       e_c;
	logic              zero_c;

	// stage d: product
	logic signed [47:0] prod_d;
	logic               zero_d;

	// stage e: exp table read
	logic signed [15:0] n_int;
	logic [IDX_W-1:0]   ex_idx;
	ex_word_t           ex_lo_e;
	ex_word_t           ex_hi_e;
	logic [REM_W-1:0]   ex_rem_e;
	logic signed [5:0]  n_e;
	logic               sat_e;
	logic               zero_e;

	// stage f: mantissa
	ex_word_t          ex_slope;
	logic [23:0]       ex_step;
	ex_word_t          mant_f;
	logic signed [5:0] n_f;
	logic              sat_f;
	logic              zero_f;

	// stage g: scale and saturate
	logic [24:0] up_sh;
	logic [24:0] dn_sh;
	logic [24:0] y_g;

	always_comb begin
		lead = '0;
		for (int i = 0; i < 25; i++) begin
			if (x[i]) lead = 5'(i);
		end
		e_sat = (e > EXP_CAP) ? EXP_CAP : e;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_a    <= x;
			e_a    <= e_sat;
			zero_a <= (x == '0);
			lead_a <= lead;
		end
	end

	// leading one moved to bit 24, fraction of the mantissa right below it
	assign norm   = x_a << (5'd24 - lead_a);
	assign lg_idx = norm[23:24-IDX_W];

	always_ff @(posedge clk) begin
		if (en) begin
			lg_lo_b  <= LG_ROM[{1'b0, lg_idx}];
			lg_hi_b  <= LG_ROM[{1'b0, lg_idx} + 11'd1];
			lg_rem_b <= norm[23-IDX_W:8];
			expo_b   <= $signed({1'b0, lead_a}) - 6'sd16;
			e_b      <= e_a;
			zero_b   <= zero_a;
		end
	end

	assign lg_slope = lg_hi_b - lg_lo_b;
	assign lg_step  = 23'(lg_slope * lg_rem_b) >> REM_W;

	always_ff @(posedge clk) begin
		if (en) begin
			lg_c   <= $signed({expo_b, 16'b0}) + $signed({5'b0, lg_lo_b})
				+ $signed({5'b0, lg_step[16:0]});
			e_c    <= e_b;
			zero_c <= zero_b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_d <= lg_c * $signed({1'b0, e_c});
			zero_d <= zero_c;
		end
	end

	// floor to Q16: integer part is bits 47:32, fraction bits 31:16
	assign n_int  = prod_d[47:32];
	assign ex_idx = prod_d[31:32-IDX_W];

	always_ff @(posedge clk) begin
		if (en) begin
			ex_lo_e  <= EX_ROM[{1'b0, ex_idx}];
			ex_hi_e  <= EX_ROM[{1'b0, ex_idx} + 11'd1];
			ex_rem_e <= prod_d[31-IDX_W:16];
			sat_e    <= (n_int >= 16'sd8);
			n_e      <= (n_int < -16'sd32) ? -6'sd32 : 6'(n_int);
			zero_e   <= zero_d;
		end
	end

	assign ex_slope = ex_hi_e - ex_lo_e;
	assign ex_step  = 24'(ex_slope * ex_rem_e) >> REM_W;

	always_ff @(posedge clk) begin
		if (en) begin
			mant_f <= ex_lo_e + ex_step[17:0];
			n_f    <= n_e;
			sat_f  <= sat_e;
			zero_f <= zero_e;
		end
	end

	assign up_sh = {7'b0, mant_f} << n_f[2:0];
	assign dn_sh = {7'b0, mant_f} >> 6'(-n_f);

	always_comb begin
		priority if (zero_f) begin
			y_g = '0;
		end else if (sat_f) begin
			y_g = EXP_CAP;
		end else if (n_f >= 6'sd0) begin
			y_g = (up_sh > EXP_CAP) ? EXP_CAP : up_sh;
		end else begin
			y_g = dn_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) y <= y_g;
	end

endmodule

`default_nettype wire

>>> rtl/core/multiscale_pixel_tone_mapper.sv
// Multiscale tone mapper for one intensity pixel and its three blurred neighborhood values.
// One pixel is accepted per clock while pix_stall is low; each result comes out of the
// fully pipelined datapath: reciprocal divide, luminance curve through two power units,
// contrast exponents and final powers through two more rows of power units (seven stages
// each), then averaging and the output choice. The last stage is the output register.
// While a result waits under res_stall the whole pipeline holds and pix_stall is raised;
// nothing is dropped or repeated. Z and P take effect on the next pixel accepted after
// the write. The user must write them only with the pipeline empty; it is not enforced.
// Depends on mptm_pkg and mptm_pow.
`default_nettype none

module multiscale_pixel_tone_mapper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       pix_valid,
	output logic       pix_stall,
	input  logic [7:0] value_in,
	input  logic [7:0] blur_small,
	input  logic [7:0] blur_mid,
	input  logic [7:0] blur_large,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] value_out
);
	import mptm_pkg::*;

	localparam logic CFG_Z_GAIN     = 1'b0;
	localparam logic CFG_P_EXPONENT = 1'b1;
	localparam int   DEPTH          = 20;
	localparam logic [19:0] DIV10_MUL = 20'd838861;

	localparam iq_tab_t  IQ_TAB  = build_iq_tab();
	localparam rcp_tab_t RCP_TAB = build_rcp_tab();

	logic [8:0] z_q;
	logic [9:0] p_q;
	logic [8:0]  z_sat;
	logic [16:0] zq;
	logic [24:0] e1;
	logic [24:0] e2;
	logic [24:0] pq;

	logic en;
	logic vld_s [1:DEPTH];
	logic [7:0] v_s [1:19];

	logic [7:0]  b_s1 [0:2];
	logic [16:0] iq_s1;
	logic [32:0] rcp_s1;

	logic [24:0] qest_s2 [0:2];
	logic [7:0]  b_s2 [0:2];
	logic [16:0] t0_s2;

	logic [8:0]  dvs;
	logic [24:0] num  [0:2];
	logic [24:0] remd [0:2];
	logic [24:0] ratio_s3 [0:2];
	logic [16:0] t_s [3:8];

	logic [24:0] pa_s8;
	logic [24:0] pb_s8;
	logic [26:0] lum_sum;
	logic [25:0] lum_half;
	logic [16:0] lum_s9;
	logic [16:0] lum_s10;
	logic [24:0] pc_s10 [0:2];
	logic [24:0] pd_s17 [0:2];
	logic [26:0] sum_s18;
	logic [33:0] rq_s19;
	logic [9:0]  fourv;
	logic [33:0] fourq;
	logic [17:0] rint;
	logic [7:0]  res;
	logic [7:0]  res_s20;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q <= '0;
			p_q <= 10'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_Z_GAIN:     z_q <= cfg_data[8:0];
				CFG_P_EXPONENT: p_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign z_sat = (z_q > 9'd256) ? 9'd256 : z_q;
	assign zq    = {z_sat, 8'b0};
	assign e1    = 25'({z_sat, 6'b0}) + 25'({z_sat, 7'b0}) + (ONE_Q >> 2);
	assign e2    = (ONE_Q << 1) - 25'(zq);
	assign pq    = 25'({p_q, 8'b0});

	// whole pipeline advances unless the output register is held
	assign pix_stall = res_valid && res_stall;
	assign en        = !pix_stall;
	assign res_valid = vld_s[DEPTH];
	assign value_out = res_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DEPTH; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= pix_valid;
			for (int i = 2; i <= DEPTH; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s[1] <= value_in;
			for (int i = 2; i <= 19; i++) v_s[i] <= v_s[i-1];
		end
	end

	// s1: capture, per-pixel tables
	always_ff @(posedge clk) begin
		if (en) begin
			b_s1[0] <= blur_small;
			b_s1[1] <= blur_mid;
			b_s1[2] <= blur_large;
			iq_s1   <= IQ_TAB[value_in];
			rcp_s1  <= RCP_TAB[value_in];
		end
	end

	// s2: quotient estimate, (1-I)(1-Z)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				qest_s2[k] <= 25'((41'({1'b0, b_s1[k]} + 9'd1) * 41'(rcp_s1)) >> 16);
				b_s2[k]    <= b_s1[k];
			end
			t0_s2 <= 17'((34'(17'(ONE_Q) - iq_s1) * 34'(17'(ONE_Q) - zq)) >> FRAC_BITS);
		end
	end

	// s3: quotient correction, t = round(0.4 * t0)
	assign dvs = {1'b0, v_s[2]} + 9'd1;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			num[k]  = {({1'b0, b_s2[k]} + 9'd1), 16'b0};
			remd[k] = num[k] - 25'(qest_s2[k] * dvs);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				ratio_s3[k] <= (remd[k] >= 25'(dvs)) ? qest_s2[k] + 25'd1 : qest_s2[k];
			end
			t_s[3] <= 17'((38'({t0_s2, 2'b0} + 19'd5) * 38'(DIV10_MUL)) >> 23);
			for (int i = 4; i <= 8; i++) t_s[i] <= t_s[i-1];
		end
	end

	mptm_pow u_pow_a (
		.clk (clk),
		.en  (en),
		.x   ({8'b0, iq_s1}),
		.e   (e1),
		.y   (pa_s8)
	);

	mptm_pow u_pow_b (
		.clk (clk),
		.en  (en),
		.x   ({8'b0, iq_s1}),
		.e   (e2),
		.y   (pb_s8)
	);

	assign lum_sum  = 27'(pa_s8) + 27'(pb_s8) + 27'(t_s[8]);
	assign lum_half = lum_sum[26:1];

	always_ff @(posedge clk) begin
		if (en) begin
			lum_s9  <= (lum_half > 26'(ONE_Q)) ? 17'(ONE_Q) : lum_half[16:0];
			lum_s10 <= lum_s9;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_scale
		mptm_pow u_pow_c (
			.clk (clk),
			.en  (en),
			.x   (ratio_s3[k]),
			.e   (pq),
			.y   (pc_s10[k])
		);

		mptm_pow u_pow_d (
			.clk (clk),
			.en  (en),
			.x   ({8'b0, lum_s10}),
			.e   (pc_s10[k]),
			.y   (pd_s17[k])
		);
	end

	// floor((0.5 + 255*S) / 3) == 85*S + 10922 exactly
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s18 <= 27'(pd_s17[0]) + 27'(pd_s17[1]) + 27'(pd_s17[2]);
			rq_s19  <= 34'(sum_s18 * 7'd85) + 34'd10922;
		end
	end

	assign fourv = {v_s[19], 2'b0};
	assign fourq = {8'b0, fourv, 16'b0};
	assign rint  = rq_s19[33:16];

	always_comb begin
		if (fourq >= rq_s19 + 34'(ONE_Q)) begin
			res = (rint > 18'd255) ? 8'd255 : rint[7:0];
		end else begin
			res = (fourv > 10'd255) ? 8'd255 : fourv[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s20 <= res;
	end

	a_valid_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_stall |=> res_valid == $past(vld_s[DEPTH-1]))
		else $error("output valid did not follow the pipeline");

	a_lum_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[10] |-> lum_s10 <= 17'(ONE_Q))
		else $error("luminance above one");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] |-> (ratio_s3[0] >= 25'd256 && ratio_s3[0] <= 25'(ONE_Q << 8)))
		else $error("blur ratio out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |=> $stable(rq_s19) && $stable(vld_s[1]))
		else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for multiscale_pixel_tone_mapper: directed and random pixels
// under random source gaps and sink stalls, checked against a fixed-point tone predictor.
// Depends on the DUT only.
`timescale 1ns / 1ps

module testbench;

	localparam bit REG_Z_GAIN     = 1'b0;
	localparam bit REG_P_EXPONENT = 1'b1;
	localparam int QF    = 16;
	localparam int DEPTH = 1024;
	localparam longint unsigned QONE  = 64'd1 << QF;
	localparam longint unsigned QMASK = QONE - 1;
	localparam longint unsigned QCAP  = QONE << 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PIPE_DRAIN  = 40;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = 1'b0;
	logic [9:0] cfg_data = '0;
	logic       pix_valid = 1'b0;
	logic       pix_stall;
	logic [7:0] value_in = '0;
	logic [7:0] blur_small = '0;
	logic [7:0] blur_mid = '0;
	logic [7:0] blur_large = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] value_out;

	longint unsigned log_lut [0:DEPTH];
	longint unsigned exp_lut [0:DEPTH];
	logic [8:0]  z_reg;
	logic [9:0]  p_reg;
	logic [7:0]  tone_expected [$];
	int          err_count = 0;
	int          cycle_count = 0;
	bit          src_no_gaps = 1'b0;
	bit          sink_no_stall = 1'b0;
	bit          sink_long_hold = 1'b0;

	multiscale_pixel_tone_mapper u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .value_in(value_in),
		.blur_small(blur_small), .blur_mid(blur_mid), .blur_large(blur_large),
		.res_valid(res_valid), .res_stall(res_stall), .value_out(value_out)
	);

	always #5 clk = ~clk;

	// ---------------- fixed-point predictor ----------------
	function automatic longint unsigned int_sqrt(longint unsigned n_in);
		longint unsigned n, r, b;
		n = n_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic fill_luts();
		longint unsigned roots [1:32];
		longint unsigned x, r, f, y;
		roots[1] = int_sqrt(64'd1 << 61);
		for (int k = 2; k <= 32; k++) roots[k] = int_sqrt(roots[k - 1] << 30);
		for (int i = 0; i < DEPTH; i++) begin
			x = ((longint'(DEPTH + i)) << 30) / DEPTH;
			r = 0;
			for (int k = 0; k < 32; k++) begin
				x = (x * x) >> 30;
				r = r << 1;
				if (x >= (64'd1 << 31)) begin
					x = x >> 1;
					r = r | 1;
				end
			end
			log_lut[i] = (r + (64'd1 << (31 - QF))) >> (32 - QF);
			f = (longint'(i) << 32) / DEPTH;
			y = 64'd1 << 30;
			for (int k = 1; k <= 32; k++)
				if (f[32 - k]) y = (y * roots[k]) >> 30;
			exp_lut[i] = (y + (64'd1 << (29 - QF))) >> (30 - QF);
		end
		log_lut[DEPTH] = QONE;
		exp_lut[DEPTH] = QONE << 1;
	endtask

	function automatic longint unsigned lut_lookup(bit use_exp, longint unsigned frac);
		longint unsigned pos, idx, rem, lo, hi;
		pos = (frac & QMASK) * DEPTH;
		idx = pos >> QF;
		rem = pos & QMASK;
		if (idx >= DEPTH) return use_exp ? exp_lut[DEPTH] : log_lut[DEPTH];
		lo = use_exp ? exp_lut[idx] : log_lut[idx];
		hi = use_exp ? exp_lut[idx + 1] : log_lut[idx + 1];
		return lo + (((hi - lo) * rem) >> QF);
	endfunction

	function automatic longint fx_log2(longint unsigned x);
		int p;
		longint unsigned m;
		p = 63;
		while (p > 0 && !x[p]) p--;
		if (p >= QF) m = x >> (p - QF);
		else m = x << (QF - p);
		return longint'(p - QF) * longint'(QONE) + longint'(lut_lookup(1'b0, m - QONE));
	endfunction

	function automatic longint unsigned fx_exp2(longint y);
		longint n;
		longint unsigned frac, mant, r;
		if (y >= 0) begin
			n = y >>> QF;
			frac = longint'(y) & QMASK;
		end else begin
			n = -longint'((longint'(-y) + QMASK) >> QF);
			frac = y - n * longint'(QONE);
		end
		if (n >= 8) return QCAP;
		mant = lut_lookup(1'b1, frac);
		if (n >= 0) r = mant << n;
		else r = (-n >= 64) ? 0 : (mant >> (-n));
		return (r > QCAP) ? QCAP : r;
	endfunction

	function automatic longint unsigned fx_pow(longint unsigned x, longint unsigned e);
		longint prod, y;
		if (x == 0) return 0;
		if (e > QCAP) e = QCAP;
		prod = fx_log2(x) * longint'(e);
		if (prod >= 0) y = prod >>> QF;
		else y = -longint'((longint'(-prod) + QMASK) >> QF);
		return fx_exp2(y);
	endfunction

	function automatic logic [7:0] predict_tone(logic [7:0] v8, logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2);
		longint unsigned v, z, iq, zq, e1, e2, t, lum, pq, sum, ratio, rq, rint, fourv, b;
		logic [7:0] blurs [3];
		blurs[0] = b0;
		blurs[1] = b1;
		blurs[2] = b2;
		v = v8;
		z = (z_reg > 256) ? 256 : z_reg;
		iq = ((v << QF) + 127) / 255;
		zq = z << (QF - 8);
		e1 = ((3 * z) << (QF - 10)) + (QONE >> 2);
		e2 = 2 * QONE - zq;
		t = ((QONE - iq) * (QONE - zq)) >> QF;
		t = (4 * t + 5) / 10;
		lum = (fx_pow(iq, e1) + t + fx_pow(iq, e2)) >> 1;
		if (lum > QONE) lum = QONE;
		pq = longint'(p_reg) << (QF - 8);
		sum = QONE >> 1;
		for (int k = 0; k < 3; k++) begin
			b = blurs[k];
			ratio = ((b + 1) << QF) / (v + 1);
			sum += 255 * fx_pow(lum, fx_pow(ratio, pq));
		end
		rq = sum / 3;
		rint = rq >> QF;
		fourv = (4 * v) << QF;
		if (fourv > rq && fourv - rq >= QONE) return (rint > 255) ? 8'd255 : rint[7:0];
		return (4 * v > 255) ? 8'd255 : 8'(4 * v);
	endfunction

	// ---------------- drivers ----------------
	task automatic write_reg(bit idx, logic [9:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_Z_GAIN) z_reg = data[8:0];
		else p_reg = data;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [7:0] v, logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
		int gap;
		pix_valid  <= 1'b1;
		value_in   <= v;
		blur_small <= b0;
		blur_mid   <= b1;
		blur_large <= b2;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		tone_expected.push_back(predict_tone(v, b0, b1, b2));
		gap = src_no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic go_idle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (tone_expected.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic send_random_pixel();
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		// mostly blurs near the pixel, as in real images
		if ($urandom_range(0, 3) != 0)
			send_pixel(v, 8'(int'(v) + $urandom_range(0, 40) - 20),
				8'(int'(v) + $urandom_range(0, 80) - 40), 8'($urandom_range(0, 255)));
		else
			send_pixel(v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
	endtask

	// ---------------- tests ----------------
	task automatic test_directed_extremes();
		send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd128, 8'd255);
		send_pixel(8'd64, 8'd64, 8'd64, 8'd64);
		send_pixel(8'd63, 8'd200, 8'd10, 8'd63);
		send_pixel(8'd128, 8'd127, 8'd129, 8'd0);
		go_idle();
		// saturated Z, P of zero, P at the top of its field
		write_reg(REG_Z_GAIN, 10'd511);
		write_reg(REG_P_EXPONENT, 10'd0);
		send_pixel(8'd0, 8'd255, 8'd0, 8'd100);
		send_pixel(8'd200, 8'd10, 8'd255, 8'd200);
		send_pixel(8'd255, 8'd0, 8'd255, 8'd128);
		go_idle();
		write_reg(REG_Z_GAIN, 10'd256);
		write_reg(REG_P_EXPONENT, 10'h3FF);
		send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd255, 8'd0, 8'd2);
		send_pixel(8'd255, 8'd0, 8'd0, 8'd255);
		send_pixel(8'd30, 8'd250, 8'd5, 8'd30);
		go_idle();
	endtask

	task automatic test_random_settings();
		logic [9:0] z_set [6] = '{10'd0, 10'd256, 10'd128, 10'd300, 10'd77, 10'd511};
		logic [9:0] p_set [6] = '{10'd256, 10'd768, 10'd512, 10'd0, 10'd1023, 10'd384};
		for (int s = 0; s < 6; s++) begin
			write_reg(REG_Z_GAIN, (s == 2) ? 10'($urandom_range(0, 256)) : z_set[s]);
			write_reg(REG_P_EXPONENT, (s == 2) ? 10'($urandom_range(256, 768)) : p_set[s]);
			src_no_gaps = (s == 4);
			sink_no_stall = (s == 4);
			repeat (80) send_random_pixel();
			go_idle();
		end
		src_no_gaps = 1'b0;
		sink_no_stall = 1'b0;
	endtask

	task automatic test_backpressure();
		write_reg(REG_Z_GAIN, 10'd200);
		write_reg(REG_P_EXPONENT, 10'd600);
		src_no_gaps = 1'b1;
		sink_long_hold = 1'b1;
		repeat (60) send_random_pixel();
		src_no_gaps = 1'b0;
		go_idle();
	endtask

	// ---------------- sink and checker ----------------
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			if (sink_long_hold) begin
				sink_long_hold = 1'b0;
				hold = 60;
			end else
				hold = sink_no_stall ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && res_valid && !res_stall) begin
			if (tone_expected.size() == 0) begin
				$error("value_out: unexpected transaction, actual %0d", value_out);
				err_count++;
			end else begin
				want = tone_expected.pop_front();
				if (value_out !== want) begin
					$error("value_out: expected %0d, actual %0d", want, value_out);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL multiscale_pixel_tone_mapper");
			$finish;
		end
	end

	initial begin
		z_reg = 9'd0;
		p_reg = 10'd256;
		fill_luts();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_random_settings();
		test_backpressure();
		if (tone_expected.size() != 0) begin
			$error("value_out: %0d transactions never arrived", tone_expected.size());
			err_count++;
		end
		if (err_count == 0)
			$display("PASS multiscale_pixel_tone_mapper");
		else
			$display("FAIL multiscale_pixel_tone_mapper");
		$finish;
	end

endmodule
